@@ rtl/fwksa_pkg.sv @@
// Shared types, constants and a helper function for the flight record queue.
package fwksa_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int OP_W          = 3;
  localparam int KIND_W        = 2;
  localparam int AIRLINE_W     = 8;
  localparam int ID_W          = 16;
  localparam int FUEL_W        = 24;
  localparam int COUNTDOWN_W   = 16;
  localparam int GROUND_W      = 16;
  localparam int COUNT_OUT_W   = 5;
  localparam int IN_DATA_W     = 80;
  localparam int OUT_DATA_W    = 88;

  // Aging constants.
  localparam logic [FUEL_W-1:0]   FUEL_BURN  = FUEL_W'(240);
  localparam logic [FUEL_W-1:0]   FUEL_MIN   = {1'b1, {(FUEL_W-1){1'b0}}};
  localparam logic [GROUND_W-1:0] GROUND_MAX = '1;

  // Queue kinds held in the configuration register.
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AIR    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GROUND = 2'd2;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_SEARCH  = 3'd2,
    OP_FRONT   = 3'd3,
    OP_COUNT   = 3'd4,
    OP_TICK    = 3'd5
  } op_t;

  // One stored record; the last field sits in the lowest bits.
  typedef struct packed {
    logic [GROUND_W-1:0]     ground_time;
    logic [COUNTDOWN_W-1:0]  countdown;
    logic signed [FUEL_W-1:0] fuel_level;
    logic [ID_W-1:0]         record_id;
    logic [AIRLINE_W-1:0]    airline_code;
  } rec_t;

  // One result; the last field sits in the lowest bits.
  typedef struct packed {
    logic [GROUND_W-1:0]      head_ground_time;
    logic [COUNTDOWN_W-1:0]   head_countdown;
    logic signed [FUEL_W-1:0] head_fuel;
    logic [ID_W-1:0]          head_id;
    logic [AIRLINE_W-1:0]     head_airline;
    logic                     dropped;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     queue_empty;
    logic                     match_found;
  } result_t;

  // Control of the record store ports.
  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } mem_req_t;

  // Circular pointer advance that also works for depths other than powers of two.
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/fwksa_store.sv @@
// Record store: one write port and one registered read port.
module fwksa_store (
  input  logic                 clk,
  input  fwksa_pkg::mem_req_t  req,
  input  fwksa_pkg::rec_t      wr_data,
  output fwksa_pkg::rec_t      rd_data
);
  import fwksa_pkg::*;

  rec_t mem [QUEUE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/fwksa_unit.sv @@
// Shared per-entry unit: key compare and aging of one record.
module fwksa_unit (
  input  logic [fwksa_pkg::KIND_W-1:0]    kind,
  input  fwksa_pkg::rec_t                 rec_in,
  input  logic [fwksa_pkg::AIRLINE_W-1:0] key_airline,
  input  logic [fwksa_pkg::ID_W-1:0]      key_id,
  output logic                            match,
  output fwksa_pkg::rec_t                 rec_out
);
  import fwksa_pkg::*;

  logic signed [FUEL_W:0] fuel_diff;

  // Key compare on the airline and id pair.
  assign match = (rec_in.airline_code == key_airline) && (rec_in.record_id == key_id);

  // Fuel burn with one guard bit to spot underflow.
  assign fuel_diff = $signed({rec_in.fuel_level[FUEL_W-1], rec_in.fuel_level})
                   - $signed({1'b0, FUEL_BURN});

  // Countdown floors at zero; fuel or ground time ages by queue kind.
  always_comb begin
    rec_out = rec_in;
    if (rec_in.countdown != '0) begin
      rec_out.countdown = rec_in.countdown - COUNTDOWN_W'(1);
    end
    if (kind == KIND_AIR) begin
      if (fuel_diff[FUEL_W] != fuel_diff[FUEL_W-1]) begin
        rec_out.fuel_level = FUEL_MIN;
      end else begin
        rec_out.fuel_level = fuel_diff[FUEL_W-1:0];
      end
    end else if (kind == KIND_GROUND) begin
      if (rec_in.ground_time != GROUND_MAX) begin
        rec_out.ground_time = rec_in.ground_time + GROUND_W'(1);
      end
    end
  end

endmodule

@@ rtl/fifo_with_key_search_and_aging.sv @@
// Top level: flight record queue with sequencer, record store and shared aging unit.
//
//   Channel   Direction  Signals                      Contents
//   s_axis    in         tvalid tready tdata tuser    one request: record or key, operation
//   m_axis    out        tvalid tready tdata          one result: status and front record
//   cfg       in         cfg_we cfg_wdata             queue kind register
//
// Enqueue, dequeue, front, count and unused codes pass through the execute, head and finish steps.
// Search and tick also walk the held entries: the record store gives one entry a cycle
// through its single read port, and the aging unit handles one entry a cycle.
// A new request is taken only while the sequencer is idle; one waiting result does not
// block it, but the sequencer stalls once the next result is ready as well.
// Reset clears pointers, occupancy and queue kind; the store needs no clearing pass.
// A stalled result holds the sequencer in its last step until the output register frees.
module fifo_with_key_search_and_aging (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // airline_code[7:0], record_id[23:8], fuel_level[47:24], countdown[63:48],
  // ground_time[79:64]
  input  logic [fwksa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation[2:0]
  input  logic [fwksa_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // match_found[0], queue_empty[1], entry_count[6:2], dropped[7], head_airline[15:8],
  // head_id[31:16], head_fuel[55:32], head_countdown[71:56], head_ground_time[87:72]
  output logic [fwksa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [fwksa_pkg::KIND_W-1:0]      cfg_wdata
);
  import fwksa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_HEAD   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t           state;
  op_t              op;
  rec_t             req_rec;
  logic [KIND_W-1:0] kind;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] wp;
  logic [CNT_W-1:0] occ;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wb_ptr;
  logic [CNT_W-1:0] issue_left;
  logic             match_acc;
  logic             dropped_r;
  logic             out_valid;
  result_t          out_data;

  mem_req_t         mem_req;
  rec_t             mem_wdata;
  rec_t             mem_rdata;
  logic             unit_match;
  rec_t             unit_rec;
  logic             full;
  logic             walk_op;
  result_t          result_next;

  assign full    = (occ >= CNT_W'(QUEUE_DEPTH));
  assign walk_op = (op == OP_SEARCH) || (op == OP_TICK);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Record store and shared per-entry unit.
  fwksa_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  fwksa_unit u_unit (
    .kind        (kind),
    .rec_in      (mem_rdata),
    .key_airline (req_rec.airline_code),
    .key_id      (req_rec.record_id),
    .match       (unit_match),
    .rec_out     (unit_rec)
  );

  // Store port control from the sequencer step.
  always_comb begin
    mem_req   = '0;
    mem_wdata = req_rec;
    unique case (state)
      ST_EXEC: begin
        if (op == OP_ENQUEUE && !full) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = wp;
        end
        if (walk_op && occ != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rp;
        end
      end
      ST_WALK: begin
        if (op == OP_TICK) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = wb_ptr;
          mem_wdata       = unit_rec;
        end
        if (issue_left != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_ptr;
        end
      end
      ST_HEAD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = rp;
      end
      ST_IDLE, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Result word; the front record reads as zeros on an empty queue.
  always_comb begin
    result_next.match_found = match_acc;
    result_next.queue_empty = (occ == '0);
    result_next.entry_count = COUNT_OUT_W'(occ);
    result_next.dropped     = dropped_r;
    if (occ != '0) begin
      result_next.head_airline     = mem_rdata.airline_code;
      result_next.head_id          = mem_rdata.record_id;
      result_next.head_fuel        = mem_rdata.fuel_level;
      result_next.head_countdown   = mem_rdata.countdown;
      result_next.head_ground_time = mem_rdata.ground_time;
    end else begin
      result_next.head_airline     = '0;
      result_next.head_id          = '0;
      result_next.head_fuel        = '0;
      result_next.head_countdown   = '0;
      result_next.head_ground_time = '0;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_NONE;
    end else if (cfg_we) begin
      kind <= cfg_wdata;
    end
  end

  // Request capture; payload registers need no reset.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op      <= op_t'(s_axis_tuser);
      req_rec <= rec_t'(s_axis_tdata);
    end
  end

  // Walk pointers, search flag and drop flag.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_EXEC: begin
        match_acc  <= 1'b0;
        dropped_r  <= (op == OP_ENQUEUE) && full;
        rd_ptr     <= ptr_next(rp);
        wb_ptr     <= rp;
        issue_left <= occ - CNT_W'(1);
      end
      ST_WALK: begin
        if (op == OP_SEARCH && unit_match) begin
          match_acc <= 1'b1;
        end
        wb_ptr <= ptr_next(wb_ptr);
        if (issue_left != '0) begin
          rd_ptr     <= ptr_next(rd_ptr);
          issue_left <= issue_left - CNT_W'(1);
        end
      end
      ST_IDLE, ST_HEAD, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, queue pointers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rp        <= '0;
      wp        <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A result taken in the finishing step is replaced there by the new one.
      if (m_axis_tvalid && m_axis_tready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (op)
            OP_ENQUEUE: begin
              if (!full) begin
                wp  <= ptr_next(wp);
                occ <= occ + CNT_W'(1);
              end
            end
            OP_DEQUEUE: begin
              if (occ != '0) begin
                rp  <= ptr_next(rp);
                occ <= occ - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          if (walk_op && occ != '0) begin
            state <= ST_WALK;
          end else begin
            state <= ST_HEAD;
          end
        end
        ST_WALK: begin
          if (issue_left == '0) begin
            state <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || m_axis_tready) begin
            out_data  <= result_next;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Occupancy never exceeds the queue depth.
  assert property (@(posedge clk) disable iff (rst) occ <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // An empty or full queue has its pointers together.
  assert property (@(posedge clk) disable iff (rst)
    (occ == '0 || occ == CNT_W'(QUEUE_DEPTH)) |-> (rp == wp))
    else $error("pointers disagree with occupancy");

  // The walk never reads the entry it is writing back.
  assert property (@(posedge clk) disable iff (rst)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
    else $error("store read and write collide");

  // Occupancy moves only in the execute step.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_EXEC) |=> $stable(occ))
    else $error("occupancy changed outside execute step");

endmodule

@@ tb/fifo_with_key_search_and_aging_tb.sv @@
// Self-checking testbench for the flight record queue with key search and aging.
module fifo_with_key_search_and_aging_tb;
  import fwksa_pkg::*;

  // Codes and limits local to the bench.
  localparam logic [OP_W-1:0]   OP_SPARE6       = 3'd6;
  localparam logic [OP_W-1:0]   OP_SPARE7       = 3'd7;
  localparam logic [KIND_W-1:0] KIND_SPARE      = 2'd3;
  localparam int                FUEL_DROP       = 240;
  localparam int                FUEL_FLOOR      = -8388608;
  localparam int                FUEL_CEIL       = 8388607;
  localparam int                SETTLE_CYCLES   = 8;
  localparam int                HOLD_CYCLES     = 300;
  localparam int                STALL_LIMIT     = 3000;
  localparam int                PHASE_ITEMS     = 115;
  localparam int                NUM_PHASES      = 6;
  localparam int                PRESSURE_PHASE  = 2;
  localparam logic [KIND_W-1:0] PHASE_KINDS [NUM_PHASES] =
    '{KIND_AIR, KIND_GROUND, KIND_SPARE, KIND_NONE, KIND_GROUND, KIND_AIR};

  // Predicts every result from the requests seen at the input and checks them in order.
  class flight_queue_scoreboard;
    rec_t              slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_ptr;
    logic [PTR_W-1:0]  tail_ptr;
    int unsigned       held;
    logic [KIND_W-1:0] kind;
    result_t           expected_q [$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       results;
    int unsigned       drops;
    int unsigned       hits;
    int unsigned       peak;

    function new();
      head_ptr = '0;
      tail_ptr = '0;
      held     = 0;
      kind     = KIND_NONE;
      errors   = 0;
      requests = 0;
      results  = 0;
      drops    = 0;
      hits     = 0;
      peak     = 0;
    endfunction

    function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function void set_kind(logic [KIND_W-1:0] k);
      kind = k;
    endfunction

    // Picks the key of one record currently held, if there is any.
    function bit pick_held(output logic [AIRLINE_W-1:0] al, output logic [ID_W-1:0] id);
      logic [PTR_W-1:0] p;
      int unsigned      k;
      al = '0;
      id = '0;
      if (held == 0) return 1'b0;
      p = head_ptr;
      k = $urandom_range(0, held - 1);
      repeat (k) p = step_ptr(p);
      al = slots[p].airline_code;
      id = slots[p].record_id;
      return 1'b1;
    endfunction

    // Applies one accepted request to the queue copy and stores the result it must give.
    function void note_request(logic [OP_W-1:0] op, rec_t r);
      result_t          res;
      logic [PTR_W-1:0] p;
      int               fuel;
      int unsigned      i;
      res = '0;
      requests++;
      case (op)
        OP_ENQUEUE: begin
          if (held >= QUEUE_DEPTH) begin
            res.dropped = 1'b1;
          end else begin
            slots[tail_ptr] = r;
            tail_ptr = step_ptr(tail_ptr);
            held++;
          end
        end
        OP_DEQUEUE: begin
          if (held > 0) begin
            head_ptr = step_ptr(head_ptr);
            held--;
          end
        end
        OP_SEARCH: begin
          p = head_ptr;
          for (i = 0; i < held; i++) begin
            if (slots[p].airline_code == r.airline_code && slots[p].record_id == r.record_id)
              res.match_found = 1'b1;
            p = step_ptr(p);
          end
        end
        OP_TICK: begin
          p = head_ptr;
          for (i = 0; i < held; i++) begin
            if (slots[p].countdown != 0)
              slots[p].countdown = slots[p].countdown - COUNTDOWN_W'(1);
            if (kind == KIND_AIR) begin
              fuel = $signed(slots[p].fuel_level);
              // Fuel stops at the most negative value instead of wrapping.
              if (fuel - FUEL_DROP < FUEL_FLOOR) fuel = FUEL_FLOOR;
              else fuel = fuel - FUEL_DROP;
              slots[p].fuel_level = fuel[FUEL_W-1:0];
            end else if (kind == KIND_GROUND) begin
              if (slots[p].ground_time != GROUND_MAX)
                slots[p].ground_time = slots[p].ground_time + GROUND_W'(1);
            end
            p = step_ptr(p);
          end
        end
        default: ;
      endcase
      res.queue_empty = (held == 0);
      res.entry_count = COUNT_OUT_W'(held);
      if (held > 0) begin
        res.head_airline     = slots[head_ptr].airline_code;
        res.head_id          = slots[head_ptr].record_id;
        res.head_fuel        = slots[head_ptr].fuel_level;
        res.head_countdown   = slots[head_ptr].countdown;
        res.head_ground_time = slots[head_ptr].ground_time;
      end
      if (held > peak) peak = held;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(result_t act);
      result_t exp;
      if (expected_q.size() == 0) begin
        $error("result 0x%0h arrived with no request outstanding", act);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      results++;
      if (exp.dropped) drops++;
      if (exp.match_found) hits++;
      compare_field("match_found", exp.match_found, act.match_found);
      compare_field("queue_empty", exp.queue_empty, act.queue_empty);
      compare_field("entry_count", exp.entry_count, act.entry_count);
      compare_field("dropped", exp.dropped, act.dropped);
      compare_field("head_airline", exp.head_airline, act.head_airline);
      compare_field("head_id", exp.head_id, act.head_id);
      compare_field("head_fuel", exp.head_fuel, act.head_fuel);
      compare_field("head_countdown", exp.head_countdown, act.head_countdown);
      compare_field("head_ground_time", exp.head_ground_time, act.head_ground_time);
    endfunction

    function void finish_check();
      if (expected_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we;
  logic [KIND_W-1:0]     cfg_wdata;

  bit                    tx_steady;
  bit                    rx_steady;
  bit                    fill_bias;
  bit                    hold_req;
  int                    idle_cycles;

  flight_queue_scoreboard sb = new();

  fifo_with_key_search_and_aging u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, rec_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) sb.check_result(result_t'(m_axis_tdata));
    end
  end

  // Ends the run if neither side moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("fifo_with_key_search_and_aging test failed");
    $finish;
  end

  // Result side: random stalls, steady stretches and one long hold-off on request.
  initial begin
    int wait_n;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      wait_n = rx_steady ? 0 : $urandom_range(0, 12);
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  function automatic rec_t make_record(logic [AIRLINE_W-1:0] al, logic [ID_W-1:0] id,
                                       int fuel, logic [COUNTDOWN_W-1:0] cd,
                                       logic [GROUND_W-1:0] gt);
    rec_t r;
    r.airline_code = al;
    r.record_id    = id;
    r.fuel_level   = fuel[FUEL_W-1:0];
    r.countdown    = cd;
    r.ground_time  = gt;
    return r;
  endfunction

  // Keys come from a small pool often enough for searches to hit; payloads lean to the edges.
  function automatic rec_t random_record();
    rec_t r;
    int   pick;
    int   fuel;
    pick = $urandom_range(0, 9);
    if (pick < 2)      r.airline_code = '0;
    else if (pick < 4) r.airline_code = '1;
    else if (pick < 7) r.airline_code = AIRLINE_W'($urandom_range(1, 3));
    else               r.airline_code = AIRLINE_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 2)      r.record_id = '0;
    else if (pick < 4) r.record_id = '1;
    else if (pick < 7) r.record_id = ID_W'($urandom_range(1, 3));
    else               r.record_id = ID_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 2)      fuel = FUEL_FLOOR + int'($urandom_range(0, 1000));
    else if (pick < 3) fuel = FUEL_CEIL - int'($urandom_range(0, 1000));
    else               fuel = int'($urandom);
    r.fuel_level = fuel[FUEL_W-1:0];
    pick = $urandom_range(0, 9);
    if (pick < 3) r.countdown = COUNTDOWN_W'($urandom_range(0, 3));
    else          r.countdown = COUNTDOWN_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 3) r.ground_time = GROUND_MAX - GROUND_W'($urandom_range(0, 3));
    else          r.ground_time = GROUND_W'($urandom);
    return r;
  endfunction

  // Offers one request after a random gap, none in steady stretches, and returns at the falling edge after acceptance.
  task automatic send_request(logic [OP_W-1:0] op, rec_t r);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_random();
    rec_t                 r;
    logic [OP_W-1:0]      op;
    logic [AIRLINE_W-1:0] al;
    logic [ID_W-1:0]      id;
    int                   roll;
    r    = random_record();
    roll = $urandom_range(0, 99);
    if (roll < (fill_bias ? 45 : 20)) begin
      op = OP_ENQUEUE;
    end else if (roll < 60) begin
      op = OP_DEQUEUE;
    end else if (roll < 75) begin
      op = OP_SEARCH;
      // About half of the searches look for a key that is really held, when the queue holds any.
      if ($urandom_range(0, 1) && sb.pick_held(al, id)) begin
        r.airline_code = al;
        r.record_id    = id;
      end
    end else if (roll < 82) begin
      op = OP_FRONT;
    end else if (roll < 87) begin
      op = OP_COUNT;
    end else if (roll < 97) begin
      op = OP_TICK;
    end else begin
      op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
    end
    send_request(op, r);
  endtask

  // Lets every outstanding request complete, then waits out a settling time.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_kind(logic [KIND_W-1:0] k);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_kind(k);
  endtask

  // Main sequence: directed requests, then random phases under each queue kind.
  initial begin
    rec_t rec_a;
    rec_t rec_b;
    rec_t rec_c;
    rec_t blank;
    int   ph;
    int   n;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ENQUEUE;
    cfg_we        = 1'b0;
    cfg_wdata     = KIND_NONE;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    fill_bias     = 1'b0;
    hold_req      = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty queue: every operation but enqueue, including the unused codes.
    blank = make_record('0, '0, 0, '0, '0);
    write_kind(KIND_NONE);
    send_request(OP_FRONT, blank);
    send_request(OP_DEQUEUE, blank);
    send_request(OP_SEARCH, blank);
    send_request(OP_TICK, blank);
    send_request(OP_COUNT, blank);
    send_request(OP_SPARE6, blank);
    send_request(OP_SPARE7, blank);

    // Records at the field extremes; one is about to underflow fuel, two near ground saturation.
    rec_a = make_record('1, '1, FUEL_FLOOR + 100, 16'd1, GROUND_MAX - GROUND_W'(1));
    rec_b = make_record('0, '0, FUEL_CEIL, '0, '0);
    rec_c = make_record(8'h55, 16'hAAAA, -1, '1, GROUND_MAX);
    send_request(OP_ENQUEUE, rec_a);
    send_request(OP_ENQUEUE, rec_b);
    send_request(OP_ENQUEUE, rec_c);
    send_request(OP_SEARCH, rec_a);
    send_request(OP_SEARCH, make_record('1, '0, 0, '0, '0));
    send_request(OP_SEARCH, rec_c);
    send_request(OP_TICK, blank);
    send_request(OP_FRONT, blank);

    // Airborne ageing saturates the front record's fuel.
    write_kind(KIND_AIR);
    send_request(OP_TICK, blank);
    send_request(OP_TICK, blank);

    // Grounded ageing saturates ground time.
    write_kind(KIND_GROUND);
    send_request(OP_TICK, blank);
    send_request(OP_TICK, blank);
    send_request(OP_DEQUEUE, blank);
    send_request(OP_COUNT, blank);
    send_request(OP_DEQUEUE, blank);
    send_request(OP_DEQUEUE, blank);
    send_request(OP_DEQUEUE, blank);
    send_request(OP_SEARCH, rec_c);

    // Random phases, each under its own queue kind.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_kind(PHASE_KINDS[ph]);
      if (ph == PRESSURE_PHASE) begin
        // Receiver stalls while enqueues arrive back to back: the queue fills and drops.
        hold_req  = 1'b1;
        tx_steady = 1'b1;
        repeat (QUEUE_DEPTH + 6) send_request(OP_ENQUEUE, random_record());
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
          fill_bias = $urandom_range(0, 1);
        end
        send_random();
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_idle();
    sb.finish_check();
    $display("Covered %0d requests and %0d results under queue kinds 0 to 3.",
             sb.requests, sb.results);
    $display("Peak occupancy %0d, %0d dropped enqueues, %0d search hits, %0d errors.",
             sb.peak, sb.drops, sb.hits, sb.errors);
    if (sb.errors == 0) begin
      $display("fifo_with_key_search_and_aging test passed");
    end else begin
      $display("fifo_with_key_search_and_aging test failed");
    end
    $finish;
  end

endmodule
